[sv/jpsm_pkg.sv]
// ----------------------------------------------------------------------------
// jpsm_pkg
// shared types and constants of the joystick pan/tilt/zoom speed mapper
// ----------------------------------------------------------------------------
package jpsm_pkg;

    localparam int ADC_BITS_DEF = 12;
    localparam int DZ_W         = 11;
    localparam int LIM_W        = 5;
    localparam int ZLIM_W       = 3;
    localparam int INT_W        = 16;
    localparam int CFG_AW       = 3;
    localparam int CFG_DW       = 16;
    localparam int PT_W         = 6;
    localparam int Z_W          = 4;
    localparam int OUT_W        = 16;
    localparam int TIME_W       = 32;
    localparam int PT_RANGE     = 24;
    localparam int ZOOM_RANGE   = 7;

    localparam logic [CFG_DW-1:0] ADC_MAX_RST  = 16'd4095;
    localparam logic [CFG_DW-1:0] CENTER_RST   = 16'd2047;
    localparam logic [DZ_W-1:0]   DZ_RST       = 11'd409;
    localparam logic [LIM_W-1:0]  PAN_LIM_RST  = 5'd15;
    localparam logic [LIM_W-1:0]  TILT_LIM_RST = 5'd15;
    localparam logic [ZLIM_W-1:0] ZOOM_LIM_RST = 3'd7;
    localparam logic [INT_W-1:0]  INTERVAL_RST = 16'd100;

    typedef enum logic [CFG_AW-1:0] {
        REG_ADC_MAX  = 3'd0,
        REG_CENTER   = 3'd1,
        REG_DZ_HALF  = 3'd2,
        REG_PAN_LIM  = 3'd3,
        REG_TILT_LIM = 3'd4,
        REG_ZOOM_LIM = 3'd5,
        REG_INTERVAL = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        AXIS_PAN  = 2'd0,
        AXIS_TILT = 2'd1,
        AXIS_ZOOM = 2'd2
    } t_axis;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_DIV  = 5'b00100,
        S_POST = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

[sv/jpsm_cfg.sv]
// ----------------------------------------------------------------------------
// jpsm_cfg
// configuration register file, written by index over the config channel
// ----------------------------------------------------------------------------
module jpsm_cfg #(
    parameter int ADC_BITS = jpsm_pkg::ADC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [jpsm_pkg::CFG_AW-1:0] i_wr_addr,
    input  logic [jpsm_pkg::CFG_DW-1:0] i_wr_data,
    output logic [ADC_BITS-1:0]         o_adc_max,
    output logic [ADC_BITS-1:0]         o_center,
    output logic [jpsm_pkg::DZ_W-1:0]   o_dz_half,
    output logic [jpsm_pkg::LIM_W-1:0]  o_pan_lim,
    output logic [jpsm_pkg::LIM_W-1:0]  o_tilt_lim,
    output logic [jpsm_pkg::ZLIM_W-1:0] o_zoom_lim,
    output logic [jpsm_pkg::INT_W-1:0]  o_interval
);

    logic [ADC_BITS-1:0]         r_adc_max;
    logic [ADC_BITS-1:0]         r_center;
    logic [jpsm_pkg::DZ_W-1:0]   r_dz_half;
    logic [jpsm_pkg::LIM_W-1:0]  r_pan_lim;
    logic [jpsm_pkg::LIM_W-1:0]  r_tilt_lim;
    logic [jpsm_pkg::ZLIM_W-1:0] r_zoom_lim;
    logic [jpsm_pkg::INT_W-1:0]  r_interval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_max  <= jpsm_pkg::ADC_MAX_RST[ADC_BITS-1:0];
            r_center   <= jpsm_pkg::CENTER_RST[ADC_BITS-1:0];
            r_dz_half  <= jpsm_pkg::DZ_RST;
            r_pan_lim  <= jpsm_pkg::PAN_LIM_RST;
            r_tilt_lim <= jpsm_pkg::TILT_LIM_RST;
            r_zoom_lim <= jpsm_pkg::ZOOM_LIM_RST;
            r_interval <= jpsm_pkg::INTERVAL_RST;
        end else if (i_wr_en) begin
            case (jpsm_pkg::t_reg_idx'(i_wr_addr))
                jpsm_pkg::REG_ADC_MAX:  r_adc_max  <= i_wr_data[ADC_BITS-1:0];
                jpsm_pkg::REG_CENTER:   r_center   <= i_wr_data[ADC_BITS-1:0];
                jpsm_pkg::REG_DZ_HALF:  r_dz_half  <= i_wr_data[jpsm_pkg::DZ_W-1:0];
                jpsm_pkg::REG_PAN_LIM:  r_pan_lim  <= i_wr_data[jpsm_pkg::LIM_W-1:0];
                jpsm_pkg::REG_TILT_LIM: r_tilt_lim <= i_wr_data[jpsm_pkg::LIM_W-1:0];
                jpsm_pkg::REG_ZOOM_LIM: r_zoom_lim <= i_wr_data[jpsm_pkg::ZLIM_W-1:0];
                jpsm_pkg::REG_INTERVAL: r_interval <= i_wr_data[jpsm_pkg::INT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_adc_max  = r_adc_max;
    assign o_center   = r_center;
    assign o_dz_half  = r_dz_half;
    assign o_pan_lim  = r_pan_lim;
    assign o_tilt_lim = r_tilt_lim;
    assign o_zoom_lim = r_zoom_lim;
    assign o_interval = r_interval;

endmodule

[sv/jpsm_div.sv]
// ----------------------------------------------------------------------------
// jpsm_div
// serial restoring divider, one quotient bit per cycle, shared by all axes
// ----------------------------------------------------------------------------
module jpsm_div #(
    parameter int NW = 17,
    parameter int DW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_quo;

    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;

    assign rem_sh = {r_rem, r_quo[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[sv/joystick_ptz_speed_mapper.sv]
// ----------------------------------------------------------------------------
// joystick_ptz_speed_mapper
// maps pan/tilt/zoom joystick readings to signed camera drive speeds
// ----------------------------------------------------------------------------
// one sample (pan, tilt, zoom readings and a ms timestamp) comes in per
// s_axis transfer; one result (speeds in tdata, send flag in tuser) leaves
// per m_axis transfer. the three axes run one after another through a
// single serial divider, each with a setup step, the division and a
// clamping step. s_axis_tready is low while a sample is in work. the
// finished result sits in an output register; the next sample may be
// taken while it waits, but its result holds in the last step until
// m_axis_tready frees the register. the config channel is always ready
// and should be written only while no sample is in work. reset
// (synchronous, active low) restores the default registers, clears the
// last send time and drops m_axis_tvalid.
// ----------------------------------------------------------------------------
module joystick_ptz_speed_mapper #(
    parameter int ADC_BITS = jpsm_pkg::ADC_BITS_DEF,
    localparam int IN_W = ((3 * ADC_BITS + jpsm_pkg::TIME_W + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pan_raw, tilt_raw, zoom_raw, now_ms
    input  logic [IN_W-1:0]             s_axis_tdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // pan_speed, tilt_speed, zoom_speed
    output logic [jpsm_pkg::OUT_W-1:0]  m_axis_tdata,
    // send_cmd
    output logic                        m_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [jpsm_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [jpsm_pkg::CFG_DW-1:0] i_cfg_data
);

    localparam int AW  = ADC_BITS;
    localparam int DZW = jpsm_pkg::DZ_W;
    localparam int HW  = ((AW > DZW) ? AW : DZW) + 1;
    localparam int NW  = AW + jpsm_pkg::LIM_W;
    localparam int SW  = NW + 2;
    localparam int TW  = jpsm_pkg::TIME_W;
    localparam int PW  = jpsm_pkg::PT_W;
    localparam int ZW  = jpsm_pkg::Z_W;
    localparam int LW  = jpsm_pkg::LIM_W;
    localparam logic signed [SW-1:0] ONE_S   = SW'(1);
    localparam logic signed [SW-1:0] PT_RNG  = SW'(jpsm_pkg::PT_RANGE);
    localparam logic signed [SW-1:0] Z_RNG   = SW'(jpsm_pkg::ZOOM_RANGE);

    logic [AW-1:0]              adc_max;
    logic [AW-1:0]              center;
    logic [DZW-1:0]             dz_half;
    logic [LW-1:0]              pan_lim;
    logic [LW-1:0]              tilt_lim;
    logic [jpsm_pkg::ZLIM_W-1:0] zoom_lim;
    logic [jpsm_pkg::INT_W-1:0] interval;

    jpsm_pkg::t_state r_state, n_state;
    jpsm_pkg::t_axis  r_axis;

    logic [AW-1:0]  r_pan_raw, r_tilt_raw, r_zoom_raw;
    logic [TW-1:0]  r_now;
    logic [TW-1:0]  r_last_send;
    logic [NW-1:0]  r_num;
    logic [HW-1:0]  r_den;
    logic           r_neg, r_zero, r_zone, r_above, r_start;
    logic [LW-1:0]  r_m;
    logic [PW-1:0]  r_pan, r_tilt;
    logic [ZW-1:0]  r_zoom;
    logic [jpsm_pkg::OUT_W-1:0] r_out_data;
    logic           r_out_user;
    logic           r_out_valid;

    logic                 div_done;
    logic [NW-1:0]        div_quo;

    // setup path
    logic [AW-1:0]        v;
    logic [LW-1:0]        m;
    logic [HW-1:0]        hi_u;
    logic signed [HW:0]   hi_s, lo_s, v_s, d_s, den_s;
    logic                 above, below;
    logic [AW-1:0]        mul_a;
    logic [LW-1:0]        mul_b, mm1;
    logic [NW-1:0]        prod;
    logic [HW-1:0]        den_mag;
    logic                 neg;

    // finish path
    logic signed [SW-1:0] q_ext, q_s, m_s, s_raw, s_cl, rng, s_neg;

    logic                 out_free;
    logic                 stop, due;

    jpsm_cfg #(.ADC_BITS(ADC_BITS)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_addr  (i_cfg_addr),
        .i_wr_data  (i_cfg_data),
        .o_adc_max  (adc_max),
        .o_center   (center),
        .o_dz_half  (dz_half),
        .o_pan_lim  (pan_lim),
        .o_tilt_lim (tilt_lim),
        .o_zoom_lim (zoom_lim),
        .o_interval (interval)
    );

    jpsm_div #(.NW(NW), .DW(HW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == jpsm_pkg::S_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;

    always_comb begin
        case (r_axis)
            jpsm_pkg::AXIS_PAN: begin
                v = r_pan_raw;
                m = pan_lim;
            end
            jpsm_pkg::AXIS_TILT: begin
                v = r_tilt_raw;
                m = tilt_lim;
            end
            jpsm_pkg::AXIS_ZOOM: begin
                v = r_zoom_raw;
                m = LW'(zoom_lim);
            end
            default: begin
                v = '0;
                m = '0;
            end
        endcase
    end

    always_comb begin
        hi_u    = HW'(center) + HW'(dz_half);
        hi_s    = $signed({1'b0, hi_u});
        lo_s    = $signed({1'b0, HW'(center)}) - $signed({1'b0, HW'(dz_half)});
        v_s     = $signed({1'b0, HW'(v)});
        above   = v_s > hi_s;
        below   = v_s < lo_s;
        d_s     = v_s - hi_s;
        mm1     = (m == '0) ? LW'(1) : m - LW'(1);
        den_s   = above ? ($signed({1'b0, HW'(adc_max)}) - hi_s) : lo_s;
        den_mag = den_s[HW] ? HW'(-den_s) : den_s[HW-1:0];
        neg     = above && ((m == '0) ^ den_s[HW]);
        mul_a   = above ? d_s[AW-1:0] : v;
        mul_b   = above ? mm1 : m;
        prod    = NW'(mul_a * mul_b);
    end

    always_comb begin
        q_ext = $signed({2'b00, div_quo});
        q_s   = r_zero ? '0 : (r_neg ? -q_ext : q_ext);
        m_s   = $signed({{(SW - LW){1'b0}}, r_m});
        s_raw = r_zone ? '0 : (r_above ? q_s + ONE_S : q_s - m_s);
        rng   = (r_axis == jpsm_pkg::AXIS_ZOOM) ? Z_RNG : PT_RNG;
        s_cl  = s_raw;
        if (s_raw > rng) begin
            s_cl = rng;
        end
        if (s_raw < -rng) begin
            s_cl = -rng;
        end
        s_neg = -s_cl;
    end

    assign stop = (r_pan == '0) && (r_tilt == '0) && (r_zoom == '0);
    assign due  = (r_now - r_last_send) > TW'(interval);

    always_comb begin
        n_state = r_state;
        case (r_state)
            jpsm_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = jpsm_pkg::S_PREP;
                end
            end
            jpsm_pkg::S_PREP: n_state = jpsm_pkg::S_DIV;
            jpsm_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = jpsm_pkg::S_POST;
                end
            end
            jpsm_pkg::S_POST: begin
                n_state = (r_axis == jpsm_pkg::AXIS_ZOOM) ? jpsm_pkg::S_DONE
                                                          : jpsm_pkg::S_PREP;
            end
            jpsm_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = jpsm_pkg::S_IDLE;
                end
            end
            default: n_state = jpsm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jpsm_pkg::S_IDLE;
            r_axis      <= jpsm_pkg::AXIS_PAN;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_send <= '0;
        end else begin
            r_state <= n_state;
            r_start <= (r_state == jpsm_pkg::S_PREP);
            if (r_state == jpsm_pkg::S_IDLE) begin
                r_axis <= jpsm_pkg::AXIS_PAN;
            end else if (r_state == jpsm_pkg::S_POST) begin
                case (r_axis)
                    jpsm_pkg::AXIS_PAN:  r_axis <= jpsm_pkg::AXIS_TILT;
                    jpsm_pkg::AXIS_TILT: r_axis <= jpsm_pkg::AXIS_ZOOM;
                    default:             r_axis <= jpsm_pkg::AXIS_ZOOM;
                endcase
            end
            if ((r_state == jpsm_pkg::S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
                if (stop || due) begin
                    r_last_send <= r_now;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_pan_raw  <= s_axis_tdata[AW-1:0];
            r_tilt_raw <= s_axis_tdata[2*AW-1:AW];
            r_zoom_raw <= s_axis_tdata[3*AW-1:2*AW];
            r_now      <= s_axis_tdata[3*AW+TW-1:3*AW];
        end
        if (r_state == jpsm_pkg::S_PREP) begin
            r_num   <= prod;
            r_den   <= den_mag;
            r_neg   <= neg;
            r_zero  <= (den_mag == '0);
            r_zone  <= !above && !below;
            r_above <= above;
            r_m     <= m;
        end
        if (r_state == jpsm_pkg::S_POST) begin
            case (r_axis)
                jpsm_pkg::AXIS_PAN:  r_pan  <= s_cl[PW-1:0];
                jpsm_pkg::AXIS_TILT: r_tilt <= s_neg[PW-1:0];
                default:             r_zoom <= s_cl[ZW-1:0];
            endcase
        end
        if ((r_state == jpsm_pkg::S_DONE) && out_free) begin
            r_out_data <= {r_zoom, r_tilt, r_pan};
            r_out_user <= stop || due;
        end
    end

    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tvalid = r_out_valid;

endmodule

[sv/jpsm_chk.sv]
// ----------------------------------------------------------------------------
// jpsm_chk
// port-level checks of the speed mapper, bound to the top level
// ----------------------------------------------------------------------------
module jpsm_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [jpsm_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                       m_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready
);

    // one sample in work at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // all axes stopped always sends
    a_stop_sends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata == '0) |-> m_axis_tuser)
        else $error("stop result without send flag");

    a_zoom_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:12] != 4'b1000)
        else $error("zoom speed out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind joystick_ptz_speed_mapper jpsm_chk u_jpsm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
